// File: src/skf_pkg.sv
// Shared types and constants for the scalar Kalman filter
// Used by the channel interfaces, the gain unit and the top level; depends on nothing
`default_nettype none

package skf_pkg;

  // field widths of the channels
  localparam int DATA_W     = 32;
  localparam int SIGMA_W    = 16;
  localparam int DIFF_W     = DATA_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // gain format, Q1.16 with one as 2^16
  localparam int GAIN_BITS = 16;
  localparam int GAIN_W    = GAIN_BITS + 1;
  localparam int GAIN_HALF = 32768;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;

  // saturation ceiling of the variance
  localparam logic [DATA_W-1:0] VAR_MAX = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_EST   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROC_SIGMA = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_SIGMA = 2'd2;

  // left shift that brings a Q16.16 square to the data format
  function automatic int sq_up(input int frac_bits);
    return (frac_bits > 16) ? (frac_bits - 16) : 0;
  endfunction

  // right shift that brings a Q16.16 square to the data format
  function automatic int sq_down(input int frac_bits);
    return (frac_bits < 16) ? (16 - frac_bits) : 0;
  endfunction

  // width of a scaled sigma square
  function automatic int sq_width(input int frac_bits);
    return 2 * SIGMA_W + sq_up(frac_bits);
  endfunction

endpackage

`default_nettype wire

// File: src/skf_if.sv
// Valid/ready channel interfaces of the scalar Kalman filter
// Measurement, result and configuration channels; depends on skf_pkg
`default_nettype none

interface skf_meas_if
  import skf_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] measurement;
  logic                     last_in_sequence;

  modport source (output valid, output measurement, output last_in_sequence, input ready);
  modport sink   (input valid, input measurement, input last_in_sequence, output ready);
endinterface

interface skf_res_if
  import skf_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] estimate;
  logic        [DATA_W-1:0] variance;
  logic        [GAIN_W-1:0] gain;
  logic                     last_out;

  modport source (output valid, output estimate, output variance, output gain,
                  output last_out, input ready);
  modport sink   (input valid, input estimate, input variance, input gain,
                  input last_out, output ready);
endinterface

interface skf_cfg_if
  import skf_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: src/skf_gain_unit.sv
// Iterative gain unit: restoring division for the gain, then shift-add products
// One compare/subtract or add step per cycle; depends on skf_pkg
`default_nettype none

module skf_gain_unit
  import skf_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             start_i,
  input  wire        [sq_width(FRAC_BITS):0]   p1_i,
  input  wire        [sq_width(FRAC_BITS)+1:0] s_i,
  input  wire signed [DIFF_W-1:0]         diff_i,
  output logic                            done_o,
  output logic       [GAIN_W-1:0]         gain_o,
  output logic signed [DIFF_W+GAIN_W:0]   corr_o,
  output logic       [sq_width(FRAC_BITS)+GAIN_W:0] red_o
);

  localparam int P1_W  = sq_width(FRAC_BITS) + 1;
  localparam int S_W   = sq_width(FRAC_BITS) + 2;
  localparam int REM_W = S_W + 1;
  localparam int CP_W  = DIFF_W + GAIN_W + 1;
  localparam int RP_W  = P1_W + GAIN_W;
  localparam int CNT_W = $clog2(GAIN_W);

  typedef enum logic [1:0] {
    U_IDLE,
    U_DIV,
    U_MUL
  } unit_state_e;

  unit_state_e              state_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [REM_W-1:0]         rem_q;
  logic [S_W-1:0]           s_q;
  logic [P1_W-1:0]          p1_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic [GAIN_W-1:0]        k_q;
  logic signed [CP_W-1:0]   acc_c_q;
  logic [RP_W-1:0]          acc_r_q;
  logic                     done_q;

  logic                     ge;
  logic [REM_W-1:0]         rem_d;
  logic                     last_step;
  logic                     k_bit;
  logic signed [CP_W-1:0]   acc_c_d;
  logic [RP_W-1:0]          acc_r_d;

  // one division step; a zero divisor yields a zero gain
  always_comb begin
    ge        = (rem_q >= REM_W'(s_q)) && (s_q != '0);
    rem_d     = (ge ? (rem_q - REM_W'(s_q)) : rem_q) << 1;
    last_step = (cnt_q == CNT_W'(GAIN_W - 1));
  end

  // one shift-add step of both products, gain msb first
  always_comb begin
    k_bit   = k_q[GAIN_W-1];
    acc_c_d = (acc_c_q <<< 1) + (k_bit ? CP_W'(diff_q) : CP_W'(0));
    acc_r_d = (acc_r_q << 1) + (k_bit ? RP_W'(p1_q) : RP_W'(0));
  end

  // sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        U_IDLE: begin
          if (start_i) begin
            rem_q   <= REM_W'(p1_i);
            s_q     <= s_i;
            p1_q    <= p1_i;
            diff_q  <= diff_i;
            k_q     <= '0;
            acc_c_q <= '0;
            acc_r_q <= '0;
            cnt_q   <= '0;
            state_q <= U_DIV;
          end
        end
        U_DIV: begin
          rem_q <= rem_d;
          k_q   <= {k_q[GAIN_W-2:0], ge};
          if (last_step) begin
            cnt_q   <= '0;
            state_q <= U_MUL;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        U_MUL: begin
          acc_c_q <= acc_c_d;
          acc_r_q <= acc_r_d;
          // rotate so the gain is whole again after the last step
          k_q     <= {k_q[GAIN_W-2:0], k_q[GAIN_W-1]};
          if (last_step) begin
            cnt_q   <= '0;
            done_q  <= 1'b1;
            state_q <= U_IDLE;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        default: state_q <= U_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign gain_o = k_q;
  assign corr_o = acc_c_q;
  assign red_o  = acc_r_q;

endmodule

`default_nettype wire

// File: src/scalar_kalman_filter_top.sv
// Scalar random-walk Kalman filter, top level with handshakes and step sequencer
// Each measurement runs the 17-step gain division followed by the 17-step shift-add
// products in skf_gain_unit; a new measurement is accepted only in idle, after the
// previous result has been loaded into the result register
// Reset: config registers, estimate and variance clear; the next beat starts a sequence
// Depends on skf_pkg, skf_if and skf_gain_unit
`default_nettype none

module scalar_kalman_filter_top
  import skf_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  skf_cfg_if.sink     cfg_i,
  skf_meas_if.sink    meas_i,
  skf_res_if.source   res_o
);

  localparam int SQ_W = sq_width(FRAC_BITS);
  localparam int UP   = sq_up(FRAC_BITS);
  localparam int DOWN = sq_down(FRAC_BITS);
  localparam int P1_W = SQ_W + 1;
  localparam int S_W  = SQ_W + 2;
  localparam int CP_W = DIFF_W + GAIN_W + 1;
  localparam int RP_W = P1_W + GAIN_W;
  localparam int RV_W = RP_W + 1 - GAIN_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_INNOV,
    ST_GAIN,
    ST_WAIT,
    ST_UPD
  } state_e;

  state_e                   state_q;

  // configuration registers
  logic signed [DATA_W-1:0] init_est_q;
  logic [SIGMA_W-1:0]       proc_sigma_q;
  logic [SIGMA_W-1:0]       meas_sigma_q;

  // filter state and the item at work
  logic signed [DATA_W-1:0] x_q;
  logic [DATA_W-1:0]        p_q;
  logic                     seq_start_q;
  logic signed [DATA_W-1:0] y_q;
  logic                     last_q;
  logic [P1_W-1:0]          p1_q;
  logic [S_W-1:0]           s_q;
  logic signed [DIFF_W-1:0] diff_q;

  // result register
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] out_est_q;
  logic [DATA_W-1:0]        out_var_q;
  logic [GAIN_W-1:0]        out_gain_q;
  logic                     out_last_q;

  logic                     in_accept;
  logic                     out_free;
  logic                     out_load;
  logic [SIGMA_W-1:0]       sigma_sel;
  logic [2*SIGMA_W-1:0]     sq_raw;
  logic [SQ_W-1:0]          sq_scaled;
  logic                     unit_done;
  logic [GAIN_W-1:0]        gain_w;
  logic signed [CP_W-1:0]   corr_w;
  logic [RP_W-1:0]          red_w;
  logic signed [CP_W-1:0]   corr_t;
  logic signed [CP_W-1:0]   corr_sh;
  logic signed [DIFF_W-1:0] x_wide;
  logic signed [DATA_W-1:0] x_new;
  logic [RP_W:0]            red_t;
  logic [RV_W-1:0]          red_v;
  logic [P1_W-1:0]          pn;
  logic [DATA_W-1:0]        pn_sat;

  assign in_accept    = meas_i.valid && meas_i.ready;
  assign meas_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign out_free     = !out_valid_q || res_o.ready;
  // result register takes a new beat in the update step, once it is free
  assign out_load     = (state_q == ST_UPD) && out_free;

  // shared squarer for q and r, scaled to the data format
  always_comb begin
    sigma_sel = (state_q == ST_PRED) ? proc_sigma_q : meas_sigma_q;
    sq_raw    = sigma_sel * sigma_sel;
    sq_scaled = (SQ_W'(sq_raw) << UP) >> DOWN;
  end

  skf_gain_unit #(
    .FRAC_BITS (FRAC_BITS)
  ) u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_GAIN),
    .p1_i    (p1_q),
    .s_i     (s_q),
    .diff_i  (diff_q),
    .done_o  (unit_done),
    .gain_o  (gain_w),
    .corr_o  (corr_w),
    .red_o   (red_w)
  );

  // rounded estimate correction and variance reduction
  always_comb begin
    corr_t  = corr_w + CP_W'(GAIN_HALF);
    corr_sh = corr_t >>> GAIN_BITS;
    x_wide  = DIFF_W'(x_q) + corr_sh[DIFF_W-1:0];
    x_new   = x_wide[DATA_W-1:0];
    red_t   = (RP_W + 1)'(red_w) + (RP_W + 1)'(GAIN_HALF);
    red_v   = red_t[RP_W:GAIN_BITS];
    pn      = (red_v >= RV_W'(p1_q)) ? '0 : (p1_q - red_v[P1_W-1:0]);
    pn_sat  = (|pn[P1_W-1:DATA_W]) ? VAR_MAX : pn[DATA_W-1:0];
  end

  // configuration writes, out-of-range indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_est_q   <= '0;
      proc_sigma_q <= '0;
      meas_sigma_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CFG_INIT_EST:   init_est_q   <= cfg_i.data[DATA_W-1:0];
        CFG_PROC_SIGMA: proc_sigma_q <= cfg_i.data[SIGMA_W-1:0];
        CFG_MEAS_SIGMA: meas_sigma_q <= cfg_i.data[SIGMA_W-1:0];
        default: ;
      endcase
    end
  end

  // step sequencer with filter state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      x_q         <= '0;
      p_q         <= '0;
      seq_start_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.valid && res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            y_q    <= meas_i.measurement;
            last_q <= meas_i.last_in_sequence;
            if (seq_start_q) begin
              x_q <= init_est_q;
              p_q <= '0;
            end
            state_q <= ST_PRED;
          end
        end
        ST_PRED: begin
          p1_q    <= P1_W'(p_q) + P1_W'(sq_scaled);
          diff_q  <= DIFF_W'(y_q) - DIFF_W'(x_q);
          state_q <= ST_INNOV;
        end
        ST_INNOV: begin
          s_q     <= S_W'(p1_q) + S_W'(sq_scaled);
          state_q <= ST_GAIN;
        end
        ST_GAIN: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (unit_done) begin
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (out_free) begin
            x_q         <= x_new;
            p_q         <= pn_sat;
            seq_start_q <= last_q;
            out_est_q   <= x_new;
            out_var_q   <= pn_sat;
            out_gain_q  <= gain_w;
            out_last_q  <= last_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.estimate = out_est_q;
  assign res_o.variance = out_var_q;
  assign res_o.gain     = out_gain_q;
  assign res_o.last_out = out_last_q;

  // an accepted beat blocks further input while it is worked on
  ap_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !meas_i.ready)
    else $error("input ready while a measurement is in work");

  // the gain never exceeds one
  ap_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.gain <= GAIN_ONE))
    else $error("gain above one");

  // a zero innovation variance gives a zero gain
  ap_zero_s_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD && s_q == '0) |-> (gain_w == '0))
    else $error("nonzero gain with zero innovation variance");

  // the update never raises the variance above the prediction
  ap_var_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> (P1_W'(pn_sat) <= p1_q))
    else $error("posterior variance above predicted variance");

  // the new estimate lies between the old estimate and the measurement
  ap_est_between: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |->
      (((x_new >= x_q) && (x_new <= y_q)) || ((x_new <= x_q) && (x_new >= y_q))))
    else $error("estimate left the interval of estimate and measurement");

endmodule

`default_nettype wire

// File: tb/sv/tb_scalar_kalman_filter_top.sv
// Self-checking testbench for the scalar random-walk Kalman filter top level
// Drives the configuration and measurement channels, checks every result beat against
// a local fixed-point filter model; depends on skf_pkg, skf_if and the DUT sources
`default_nettype none

module tb_scalar_kalman_filter_top;
  import skf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS      = 16;
  localparam int RESULT_LATENCY = 39;
  localparam int SETTLE_CYCLES  = RESULT_LATENCY + 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1700;

  // index that maps to no register, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [DATA_W-1:0] estimate;
    logic        [DATA_W-1:0] variance;
    logic        [GAIN_W-1:0] gain;
    logic                     last;
  } kf_result_t;

  logic clk;
  logic rst_n;

  skf_cfg_if  cfg_if ();
  skf_meas_if meas_if ();
  skf_res_if  res_if ();

  scalar_kalman_filter_top #(
    .FRAC_BITS (FRAC_BITS)
  ) DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .meas_i (meas_if),
    .res_o  (res_if)
  );

  // filter model state and its copy of the registers
  logic signed [DATA_W-1:0]  init_estimate;
  logic        [SIGMA_W-1:0] proc_sigma;
  logic        [SIGMA_W-1:0] meas_sigma;
  logic signed [DATA_W-1:0]  filt_estimate;
  logic        [DATA_W-1:0]  filt_variance;
  logic                      seq_fresh;

  kf_result_t pending_results[$];
  int         error_count;
  logic       steady_flow;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // noise power from a Q8.8 sigma, brought to the data format
  function automatic logic [63:0] noise_power(input logic [SIGMA_W-1:0] sigma);
    logic [63:0] sq;
    sq = 64'(sigma) * 64'(sigma);
    if (FRAC_BITS >= 16) return sq << (FRAC_BITS - 16);
    return sq >> (16 - FRAC_BITS);
  endfunction

  // one filter step: predict, gain, update of estimate and variance
  function automatic kf_result_t kalman_predict(input logic signed [DATA_W-1:0] y_in,
                                                input logic last_in);
    logic [63:0] p1, s, k, red, pn;
    longint      x, y, corr;
    kf_result_t  res;
    if (seq_fresh) begin
      filt_estimate = init_estimate;
      filt_variance = '0;
    end
    x  = longint'(filt_estimate);
    y  = longint'(y_in);
    p1 = 64'(filt_variance) + noise_power(proc_sigma);
    s  = p1 + noise_power(meas_sigma);
    // zero innovation variance gives zero gain
    k  = (s == 0) ? 64'd0 : ((p1 << GAIN_BITS) / s);
    if (k > 64'(GAIN_ONE)) k = 64'(GAIN_ONE);
    // correction rounded to nearest, ties towards plus infinity
    corr = (longint'(k) * (y - x) + longint'(GAIN_HALF)) >>> GAIN_BITS;
    x    = x + corr;
    red  = (k * p1 + 64'(GAIN_HALF)) >> GAIN_BITS;
    pn   = (red >= p1) ? 64'd0 : (p1 - red);
    // variance saturates at the top of its range
    if (pn > 64'(VAR_MAX)) pn = 64'(VAR_MAX);
    filt_estimate = 32'(x);
    filt_variance = pn[DATA_W-1:0];
    seq_fresh     = last_in;
    res.estimate  = filt_estimate;
    res.variance  = filt_variance;
    res.gain      = k[GAIN_W-1:0];
    res.last      = last_in;
    return res;
  endfunction

  function automatic int pick_wait();
    return steady_flow ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic logic [DATA_W-1:0] pick_extreme_word();
    case ($urandom_range(0, 3))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic [SIGMA_W-1:0] pick_sigma();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return SIGMA_W'($urandom_range(0, 16'h0100));
      3:       return SIGMA_W'($urandom_range(0, 16'h1000));
      default: return SIGMA_W'($urandom());
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] ERROR: %s", $time, msg);
  endtask

  // one configuration write, applied to the model at its beat
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    repeat (pick_wait()) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    case (idx)
      CFG_INIT_EST:   init_estimate = value;
      CFG_PROC_SIGMA: proc_sigma    = value[SIGMA_W-1:0];
      CFG_MEAS_SIGMA: meas_sigma    = value[SIGMA_W-1:0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // one measurement beat, valid held over when the next gap is zero
  task automatic send_measurement(input logic [DATA_W-1:0] value, input logic last);
    int gap;
    gap = pick_wait();
    if (gap > 0) begin
      meas_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    meas_if.valid            <= 1'b1;
    meas_if.measurement      <= value;
    meas_if.last_in_sequence <= last;
    do @(posedge clk); while (meas_if.ready !== 1'b1);
    pending_results.push_back(kalman_predict(value, last));
  endtask

  // stop sending and wait for every outstanding result
  task automatic wait_drained();
    meas_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // registers still at reset: both sigmas zero, so the gain is zero
  task automatic test_zero_innovation();
    send_measurement(32'h7FFF_FFFF, 1'b0);
    send_measurement(32'h8000_0000, 1'b0);
    send_measurement(32'h0000_0000, 1'b1);
    wait_drained();
  endtask

  // write to the spare index must leave the registers alone
  task automatic test_unused_index();
    write_register(CFG_UNUSED, $urandom());
    send_measurement($urandom(), 1'b1);
    wait_drained();
  endtask

  // extreme registers and measurements, longest difference between estimate and sample
  task automatic test_field_extremes();
    write_register(CFG_INIT_EST, 32'h8000_0000);
    write_register(CFG_PROC_SIGMA, 32'hFFFF_FFFF);
    write_register(CFG_MEAS_SIGMA, 32'h0000_FFFF);
    repeat (4) send_measurement(32'h7FFF_FFFF, 1'b0);
    send_measurement(32'h8000_0000, 1'b0);
    send_measurement(32'h7FFF_FFFF, 1'b1);
    wait_drained();
    // no measurement noise: gain of one
    write_register(CFG_INIT_EST, 32'h7FFF_FFFF);
    write_register(CFG_MEAS_SIGMA, 32'h0000_0000);
    send_measurement(32'h8000_0000, 1'b0);
    send_measurement(32'h7FFF_FFFF, 1'b1);
    wait_drained();
    // no process noise: gain stays zero
    write_register(CFG_PROC_SIGMA, 32'h0000_0000);
    write_register(CFG_MEAS_SIGMA, 32'h0000_FFFF);
    send_measurement(32'h8000_0000, 1'b0);
    send_measurement(32'hFFFF_FFFF, 1'b1);
    wait_drained();
    // smallest non-zero sigmas
    write_register(CFG_PROC_SIGMA, 32'h0000_0001);
    write_register(CFG_MEAS_SIGMA, 32'h0000_0001);
    send_measurement(32'h0001_0000, 1'b0);
    send_measurement(32'hFFFF_0000, 1'b1);
    wait_drained();
  endtask

  // register change inside a sequence; the start estimate waits for the next sequence
  task automatic test_midsequence_change();
    write_register(CFG_INIT_EST, 32'h0001_0000);
    write_register(CFG_PROC_SIGMA, 32'h0000_0100);
    write_register(CFG_MEAS_SIGMA, 32'h0000_0200);
    send_measurement(32'h0002_0000, 1'b0);
    send_measurement(32'h0003_8000, 1'b0);
    send_measurement(32'hFFFE_0000, 1'b0);
    wait_drained();
    write_register(CFG_INIT_EST, 32'hFFFB_0000);
    write_register(CFG_PROC_SIGMA, 32'h0000_0040);
    write_register(CFG_MEAS_SIGMA, 32'h0000_0800);
    send_measurement(32'h0004_0000, 1'b0);
    send_measurement(32'h0004_4000, 1'b1);
    send_measurement(32'h0000_0000, 1'b1);
    wait_drained();
  endtask

  // random phases of settings, noisy sequences around a level with stray samples
  task automatic test_random_sequences();
    int          sent;
    int          seq_left;
    int          amp;
    logic [31:0] level;
    logic [31:0] y;
    logic        first;
    sent     = 0;
    seq_left = 0;
    amp      = 1;
    level    = '0;
    first    = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      wait_drained();
      steady_flow = ($urandom_range(0, 3) == 0);
      if (first || $urandom_range(0, 2) != 0) begin
        write_register(CFG_INIT_EST,
                       ($urandom_range(0, 2) == 0) ? pick_extreme_word() : $urandom());
      end
      if (first || $urandom_range(0, 2) != 0)
        write_register(CFG_PROC_SIGMA, {16'($urandom()), pick_sigma()});
      if (first || $urandom_range(0, 2) != 0)
        write_register(CFG_MEAS_SIGMA, {16'($urandom()), pick_sigma()});
      if ($urandom_range(0, 7) == 0) write_register(CFG_UNUSED, $urandom());
      first = 1'b0;
      repeat ($urandom_range(30, 120)) begin
        if (seq_left == 0) begin
          seq_left = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 48)
                                                 : $urandom_range(1, 12);
          level    = $urandom();
          amp      = 1 << $urandom_range(0, 24);
        end
        case ($urandom_range(0, 7))
          0:       y = $urandom();
          1:       y = pick_extreme_word();
          default: y = level + 32'($urandom_range(0, 2 * amp)) - 32'(amp);
        endcase
        send_measurement(y, seq_left == 1);
        seq_left--;
        sent++;
      end
    end
    steady_flow = 1'b0;
  endtask

  // result side: random stall per beat, then compare against the oldest prediction
  initial begin : result_sink
    int         stall;
    kf_result_t want;
    res_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = pick_wait();
      if (stall == 0) begin
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= 1'b0;
        do @(posedge clk); while (res_if.valid !== 1'b1);
        repeat (stall - 1) @(posedge clk);
        res_if.ready <= 1'b1;
      end
      do @(posedge clk); while (res_if.valid !== 1'b1);
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected, estimate %h",
                                  res_if.estimate));
      end else begin
        want = pending_results.pop_front();
        if (res_if.estimate !== want.estimate)
          report_mismatch($sformatf("estimate %h, expected %h",
                                    res_if.estimate, want.estimate));
        if (res_if.variance !== want.variance)
          report_mismatch($sformatf("variance %h, expected %h",
                                    res_if.variance, want.variance));
        if (res_if.gain !== want.gain)
          report_mismatch($sformatf("gain %h, expected %h", res_if.gain, want.gain));
        if (res_if.last_out !== want.last)
          report_mismatch($sformatf("last_out %b, expected %b",
                                    res_if.last_out, want.last));
      end
    end
  end

  // watchdog on cycles without any beat on any channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((meas_if.valid === 1'b1 && meas_if.ready === 1'b1) ||
          (res_if.valid === 1'b1 && res_if.ready === 1'b1) ||
          (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("** scalar_kalman_filter_top: FAILED **");
    $finish;
  end

  // reset, then the tests in turn
  initial begin
    error_count              = 0;
    steady_flow              = 1'b0;
    init_estimate            = '0;
    proc_sigma               = '0;
    meas_sigma               = '0;
    filt_estimate            = '0;
    filt_variance            = '0;
    seq_fresh                = 1'b1;
    rst_n                   <= 1'b0;
    cfg_if.valid            <= 1'b0;
    cfg_if.index            <= '0;
    cfg_if.data             <= '0;
    meas_if.valid           <= 1'b0;
    meas_if.measurement     <= '0;
    meas_if.last_in_sequence <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_innovation();
    test_unused_index();
    test_field_extremes();
    test_midsequence_change();
    test_random_sequences();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("** scalar_kalman_filter_top: PASSED **");
    else
      $display("** scalar_kalman_filter_top: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

// File: scalar_kalman_filter_top.f
src/skf_pkg.sv
src/skf_if.sv
src/skf_gain_unit.sv
src/scalar_kalman_filter_top.sv
tb/sv/tb_scalar_kalman_filter_top.sv
